// ----- hdl/tpq_pkg.sv -----
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared widths, operation and status codes, and the per-cell command bundle
// of the task priority queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

	localparam int ID_W    = 15;
	localparam int PRI_W   = 16;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

	// command broadcast to every cell in a cycle
	typedef struct packed {
		logic enq;    // insert key entry at its sorted place
		logic deq;    // every cell takes its successor's entry
		logic rem;    // cells not yet scanned take their successor's entry
		logic start;  // begin a search: clear the scanned marks
		logic step;   // search advances by one cell
	} tpq_cmd_t;

endpackage

// ----- hdl/tpq_cell.sv -----
// ----------------------------------------------------------------------------
// tpq_cell
// One slot of the sorted queue. Holds an entry, decides locally whether it
// keeps it, takes its neighbor's or takes the new one, and carries the mark
// of the id search token.
// ----------------------------------------------------------------------------
module tpq_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tpq_pkg::tpq_cmd_t          cmd,
	input  logic                       occ,
	input  logic [tpq_pkg::ID_W-1:0]   key_id,
	input  logic signed [tpq_pkg::PRI_W-1:0] key_pri,
	input  logic                       prev_lower,
	input  logic                       prev_passed,
	input  logic [tpq_pkg::ID_W-1:0]   prev_id,
	input  logic signed [tpq_pkg::PRI_W-1:0] prev_pri,
	input  logic [tpq_pkg::ID_W-1:0]   next_id,
	input  logic signed [tpq_pkg::PRI_W-1:0] next_pri,
	output logic                       lower,
	output logic                       passed,
	output logic                       tok,
	output logic                       hit,
	output logic [tpq_pkg::ID_W-1:0]   ent_id,
	output logic signed [tpq_pkg::PRI_W-1:0] ent_pri
);

	logic [tpq_pkg::ID_W-1:0]         id_q;
	logic signed [tpq_pkg::PRI_W-1:0] pri_q;
	logic                             passed_q;

	// free slot or strictly lower priority: the new entry goes at or before here
	assign lower  = !occ || (pri_q < key_pri);
	assign tok    = !passed_q && prev_passed;
	assign hit    = tok && occ && (id_q == key_id);
	assign passed = passed_q;
	assign ent_id  = id_q;
	assign ent_pri = pri_q;

	always_ff @(posedge clk) begin
		if (cmd.enq && lower) begin
			if (prev_lower) begin
				id_q  <= prev_id;
				pri_q <= prev_pri;
			end else begin
				id_q  <= key_id;
				pri_q <= key_pri;
			end
		end else if (cmd.deq || (cmd.rem && !passed_q)) begin
			id_q  <= next_id;
			pri_q <= next_pri;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			passed_q <= 1'b0;
		end else if (cmd.start) begin
			passed_q <= 1'b0;
		end else if (cmd.step) begin
			passed_q <= passed_q | tok;
		end
	end

endmodule

// ----- hdl/task_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// task_priority_queue_unit
// Sorted task queue as a row of cells, highest priority at the head.
// Enqueue and dequeue take one item per cycle unless a search runs or a held result stalls
// the input; the result is registered and shows in the cycle after accept. Remove walks a
// search token one cell per cycle from the head; input stalls until it hits or misses.
// Reset clears the count, search marks and output valid; entry data is not reset.
// ----------------------------------------------------------------------------
module task_priority_queue_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [tpq_pkg::OP_W-1:0]          operation,
	input  logic [tpq_pkg::ID_W-1:0]          task_id,
	input  logic signed [tpq_pkg::PRI_W-1:0]  task_priority,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tpq_pkg::STAT_W-1:0]        status,
	output logic [tpq_pkg::ID_W-1:0]          result_id,
	output logic signed [tpq_pkg::PRI_W-1:0]  result_priority,
	output logic [tpq_pkg::COUNT_W-1:0]       entry_count
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic                             state_q;
	logic [CNT_W-1:0]                 count_q;
	logic [tpq_pkg::ID_W-1:0]         key_q;
	logic                             out_valid_q;
	logic [tpq_pkg::STAT_W-1:0]       status_q;
	logic [tpq_pkg::ID_W-1:0]         rid_q;
	logic signed [tpq_pkg::PRI_W-1:0] rpri_q;
	logic [CNT_W-1:0]                 rcount_q;

	tpq_pkg::tpq_cmd_t cmd;
	logic                             accept;
	logic [tpq_pkg::ID_W-1:0]         key_id;

	logic [QUEUE_DEPTH-1:0] occ, lower, passed, tok, hit;
	logic [tpq_pkg::ID_W-1:0]         ent_id  [QUEUE_DEPTH];
	logic signed [tpq_pkg::PRI_W-1:0] ent_pri [QUEUE_DEPTH];

	logic                             any_hit, miss;
	logic [tpq_pkg::ID_W-1:0]         hit_id;
	logic [tpq_pkg::PRI_W-1:0]        hit_pri;

	logic                             res_load;
	logic [tpq_pkg::STAT_W-1:0]       res_status;
	logic [tpq_pkg::ID_W-1:0]         res_id;
	logic signed [tpq_pkg::PRI_W-1:0] res_pri;
	logic [CNT_W-1:0]                 res_count;

	assign in_stall = (state_q == S_SCAN) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign key_id   = (state_q == S_SCAN) ? key_q : task_id;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                             p_lower, p_passed;
		logic [tpq_pkg::ID_W-1:0]         p_id, n_id;
		logic signed [tpq_pkg::PRI_W-1:0] p_pri, n_pri;

		assign occ[i] = count_q > CNT_W'(i);

		if (i == 0) begin : g_head
			assign p_lower  = 1'b0;
			assign p_passed = 1'b1;
			assign p_id     = '0;
			assign p_pri    = '0;
		end else begin : g_body
			assign p_lower  = lower[i-1];
			assign p_passed = passed[i-1];
			assign p_id     = ent_id[i-1];
			assign p_pri    = ent_pri[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign n_id  = '0;
			assign n_pri = '0;
		end else begin : g_mid
			assign n_id  = ent_id[i+1];
			assign n_pri = ent_pri[i+1];
		end

		tpq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.occ         (occ[i]),
			.key_id      (key_id),
			.key_pri     (task_priority),
			.prev_lower  (p_lower),
			.prev_passed (p_passed),
			.prev_id     (p_id),
			.prev_pri    (p_pri),
			.next_id     (n_id),
			.next_pri    (n_pri),
			.lower       (lower[i]),
			.passed      (passed[i]),
			.tok         (tok[i]),
			.hit         (hit[i]),
			.ent_id      (ent_id[i]),
			.ent_pri     (ent_pri[i])
		);
	end

	// at most one cell holds the token, so an or of the gated entries selects it
	always_comb begin
		hit_id  = '0;
		hit_pri = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			hit_id  = hit_id  | (ent_id[i]  & {tpq_pkg::ID_W{hit[i]}});
			hit_pri = hit_pri | (ent_pri[i] & {tpq_pkg::PRI_W{hit[i]}});
		end
	end

	assign any_hit = |hit;
	// token reached a free slot or ran off the end of a full row
	assign miss    = (|(tok & ~occ)) || passed[QUEUE_DEPTH-1];

	always_comb begin
		cmd        = '0;
		res_load   = 1'b0;
		res_status = tpq_pkg::ST_OK;
		res_id     = '0;
		res_pri    = '0;
		res_count  = count_q;
		if (state_q == S_SCAN) begin
			if (any_hit) begin
				cmd.rem   = 1'b1;
				res_load  = 1'b1;
				res_id    = hit_id;
				res_pri   = hit_pri;
				res_count = count_q - 1'b1;
			end else if (miss) begin
				res_load   = 1'b1;
				res_status = tpq_pkg::ST_NOT_FOUND;
			end else begin
				cmd.step = 1'b1;
			end
		end else if (accept) begin
			case (operation)
				tpq_pkg::OP_ENQUEUE: begin
					res_load = 1'b1;
					if (count_q >= DEPTH_C) begin
						res_status = tpq_pkg::ST_FULL;
					end else begin
						cmd.enq   = 1'b1;
						res_id    = task_id;
						res_pri   = task_priority;
						res_count = count_q + 1'b1;
					end
				end
				tpq_pkg::OP_DEQUEUE: begin
					res_load = 1'b1;
					if (count_q == '0) begin
						res_status = tpq_pkg::ST_EMPTY;
					end else begin
						cmd.deq   = 1'b1;
						res_id    = ent_id[0];
						res_pri   = ent_pri[0];
						res_count = count_q - 1'b1;
					end
				end
				tpq_pkg::OP_REMOVE: begin
					if (count_q == '0) begin
						res_load   = 1'b1;
						res_status = tpq_pkg::ST_EMPTY;
					end else begin
						cmd.start = 1'b1;
					end
				end
				default: begin
					res_load = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= res_count;
			if (cmd.start) begin
				state_q <= S_SCAN;
			end else if (res_load) begin
				state_q <= S_IDLE;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= task_id;
		end
		if (res_load) begin
			status_q <= res_status;
			rid_q    <= res_id;
			rpri_q   <= res_pri;
			rcount_q <= res_count;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign result_id       = rid_q;
	assign result_priority = rpri_q;
	assign entry_count     = tpq_pkg::COUNT_W'(rcount_q);

`ifndef SYNTHESIS
	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above queue depth");

	a_single_hit : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> $onehot0(hit))
		else $error("more than one cell matched the search token");

	a_scan_no_result : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !out_valid_q)
		else $error("result pending while a search runs");

	a_full_count : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == tpq_pkg::ST_FULL) |-> (count_q == DEPTH_C))
		else $error("full status with a queue that is not full");
`endif

endmodule
